// ===== src/pff_pkg.sv =====
// Shared types, constants and helpers for the pane frustum field-of-view fit.
package pff_pkg;

  localparam int COORD_BITS_DEF = 21;
  localparam int DIR_BITS_DEF   = 16;

  localparam int POS_W      = 63;
  localparam int VEC_W      = 48;
  localparam int ASPECT_W   = 16;
  localparam int ANG_W      = 16;
  localparam int MARGIN_W   = 16;
  localparam int FLOOR_W    = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int N_CORNER    = 4;
  localparam int N_TAN       = 8;
  localparam int TAN_W       = 32;
  localparam int FLOOR_SHIFT = 14;
  localparam int DIV_SHIFT   = 24;
  localparam int VERT_SHIFT  = 8;

  localparam int MARGIN_FRAC   = 14;
  localparam int SCALED_W      = TAN_W + MARGIN_W + 1 - MARGIN_FRAC;
  localparam int CORDIC_STEPS  = 24;
  localparam int CORDIC_PRE    = 20;
  localparam int CORDIC_X0_SH  = 16 + CORDIC_PRE;
  localparam int XY_W          = 58;
  localparam int Z_W           = 27;
  localparam int ANG_FULL_W    = 17;
  localparam int ANG_ROUND     = 256;
  localparam int ANG_SHIFT     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_FOV_MIN    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOV_MAX    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MARGIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FLR  = 8'd3;

  localparam logic [ANG_W-1:0]    FOV_MIN_RST    = 16'd328;
  localparam logic [ANG_W-1:0]    FOV_MAX_RST    = 16'd49152;
  localparam logic [MARGIN_W-1:0] FIT_MARGIN_RST = 16'd16712;
  localparam logic [FLOOR_W-1:0]  DEPTH_FLR_RST  = 20'd1;

  typedef struct packed {
    logic [POS_W-1:0]    eye_position;
    logic [VEC_W-1:0]    view_forward;
    logic [VEC_W-1:0]    view_right;
    logic [VEC_W-1:0]    view_up;
    logic [POS_W-1:0]    pane_centre;
    logic [POS_W-1:0]    pane_half_axis_a;
    logic [POS_W-1:0]    pane_half_axis_b;
    logic [ASPECT_W-1:0] aspect_ratio;
  } pff_in_t;

  typedef struct packed {
    logic [ANG_W-1:0] field_of_view;
    logic             saturated;
  } pff_out_t;

  typedef struct packed {
    logic vld;
    logic zero;
    logic sat;
  } pff_side_t;

  function automatic int mag_w(int coord_bits, int dir_bits);
    return coord_bits + dir_bits + 2;
  endfunction

  function automatic int dep_w(int coord_bits, int dir_bits);
    int m;
    m = mag_w(coord_bits, dir_bits);
    return (m > FLOOR_W + FLOOR_SHIFT) ? m : FLOOR_W + FLOOR_SHIFT;
  endfunction

  function automatic int num_w(int coord_bits, int dir_bits);
    return mag_w(coord_bits, dir_bits) + DIV_SHIFT;
  endfunction

  function automatic int den_w(int coord_bits, int dir_bits);
    return dep_w(coord_bits, dir_bits) + ASPECT_W;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_q24(int i);
    case (i)
      0:  return 27'sd13176795;
      1:  return 27'sd7778716;
      2:  return 27'sd4110060;
      3:  return 27'sd2086331;
      4:  return 27'sd1047214;
      5:  return 27'sd524117;
      6:  return 27'sd262123;
      7:  return 27'sd131069;
      8:  return 27'sd65536;
      9:  return 27'sd32768;
      10: return 27'sd16384;
      11: return 27'sd8192;
      12: return 27'sd4096;
      13: return 27'sd2048;
      14: return 27'sd1024;
      15: return 27'sd512;
      16: return 27'sd256;
      17: return 27'sd128;
      18: return 27'sd64;
      19: return 27'sd32;
      20: return 27'sd16;
      21: return 27'sd8;
      22: return 27'sd4;
      23: return 27'sd2;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== src/pff_geom.sv =====
// Corner offsets, dot products, floored depths and divider operands (four stages).
module pff_geom #(
  parameter int COORD_BITS = pff_pkg::COORD_BITS_DEF,
  parameter int DIR_BITS   = pff_pkg::DIR_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               en,
  input  logic                                               in_vld,
  input  pff_pkg::pff_in_t                                   in_data,
  input  logic [pff_pkg::FLOOR_W-1:0]                        depth_floor,
  output pff_pkg::pff_side_t                                 side_o,
  output logic [pff_pkg::num_w(COORD_BITS, DIR_BITS)-1:0]   num_o [pff_pkg::N_TAN],
  output logic [pff_pkg::den_w(COORD_BITS, DIR_BITS)-1:0]   den_o [pff_pkg::N_TAN]
);
  import pff_pkg::*;

  localparam int OFF_W  = COORD_BITS + 2;
  localparam int PROD_W = OFF_W + DIR_BITS;
  localparam int MAG_W  = mag_w(COORD_BITS, DIR_BITS);
  localparam int DOT_W  = MAG_W + 1;
  localparam int DEP_W  = dep_w(COORD_BITS, DIR_BITS);
  localparam int NUM_W  = num_w(COORD_BITS, DIR_BITS);
  localparam int DEN_W  = den_w(COORD_BITS, DIR_BITS);

  logic signed [OFF_W-1:0]    off_nxt  [N_CORNER][3];
  logic signed [OFF_W-1:0]    off_r    [N_CORNER][3];
  logic signed [DIR_BITS-1:0] dir_nxt  [3][3];
  logic signed [DIR_BITS-1:0] dir_r    [3][3];
  logic [ASPECT_W-1:0]        asp1_r, asp2_r, asp3_r;
  logic signed [PROD_W-1:0]   prod_nxt [N_CORNER][3][3];
  logic signed [PROD_W-1:0]   prod_r   [N_CORNER][3][3];
  logic [DEP_W-1:0]           depth_nxt [N_CORNER];
  logic [DEP_W-1:0]           depth_r   [N_CORNER];
  logic [MAG_W-1:0]           magr_nxt  [N_CORNER];
  logic [MAG_W-1:0]           magr_r    [N_CORNER];
  logic [MAG_W-1:0]           magu_nxt  [N_CORNER];
  logic [MAG_W-1:0]           magu_r    [N_CORNER];
  logic [NUM_W-1:0]           num_nxt   [N_TAN];
  logic [NUM_W-1:0]           num_r     [N_TAN];
  logic [DEN_W-1:0]           den_nxt   [N_TAN];
  logic [DEN_W-1:0]           den_r     [N_TAN];
  pff_side_t                  side_nxt;
  pff_side_t                  side_r    [4];

  always_comb begin
    logic signed [OFF_W-1:0] e, cn, a, b;
    for (int c = 0; c < 3; c++) begin
      e  = OFF_W'($signed(in_data.eye_position[c*COORD_BITS +: COORD_BITS]));
      cn = OFF_W'($signed(in_data.pane_centre[c*COORD_BITS +: COORD_BITS]));
      a  = OFF_W'($signed(in_data.pane_half_axis_a[c*COORD_BITS +: COORD_BITS]));
      b  = OFF_W'($signed(in_data.pane_half_axis_b[c*COORD_BITS +: COORD_BITS]));
      for (int k = 0; k < N_CORNER; k++) begin
        off_nxt[k][c] = cn + ((k >= 2) ? a : -a) + ((k == 1 || k == 3) ? b : -b) - e;
      end
      dir_nxt[0][c] = $signed(in_data.view_forward[c*DIR_BITS +: DIR_BITS]);
      dir_nxt[1][c] = $signed(in_data.view_right[c*DIR_BITS +: DIR_BITS]);
      dir_nxt[2][c] = $signed(in_data.view_up[c*DIR_BITS +: DIR_BITS]);
    end
    side_nxt.vld  = in_vld;
    side_nxt.zero = (in_data.aspect_ratio == '0);
    side_nxt.sat  = 1'b0;
  end

  always_comb begin
    for (int k = 0; k < N_CORNER; k++) begin
      for (int v = 0; v < 3; v++) begin
        for (int c = 0; c < 3; c++) begin
          prod_nxt[k][v][c] = PROD_W'(off_r[k][c]) * PROD_W'(dir_r[v][c]);
        end
      end
    end
  end

  always_comb begin
    logic signed [DOT_W-1:0] dot [3];
    logic signed [DOT_W-1:0] neg_r, neg_u;
    logic [DEP_W-1:0]        fl, df;
    fl = ((depth_floor == '0) ? DEP_W'(1) : DEP_W'(depth_floor)) << FLOOR_SHIFT;
    for (int k = 0; k < N_CORNER; k++) begin
      for (int v = 0; v < 3; v++) begin
        dot[v] = DOT_W'(prod_r[k][v][0]) + DOT_W'(prod_r[k][v][1]) + DOT_W'(prod_r[k][v][2]);
      end
      df    = DEP_W'(dot[0][MAG_W-1:0]);
      neg_r = -dot[1];
      neg_u = -dot[2];
      depth_nxt[k] = (!dot[0][DOT_W-1] && df > fl) ? df : fl;
      magr_nxt[k]  = dot[1][DOT_W-1] ? neg_r[MAG_W-1:0] : dot[1][MAG_W-1:0];
      magu_nxt[k]  = dot[2][DOT_W-1] ? neg_u[MAG_W-1:0] : dot[2][MAG_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < N_CORNER; k++) begin
      num_nxt[2*k]   = NUM_W'(magu_r[k]) << DIV_SHIFT;
      num_nxt[2*k+1] = NUM_W'(magr_r[k]) << DIV_SHIFT;
      den_nxt[2*k]   = DEN_W'(depth_r[k]) << VERT_SHIFT;
      den_nxt[2*k+1] = DEN_W'(depth_r[k]) * DEN_W'(asp3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r   <= off_nxt;
      dir_r   <= dir_nxt;
      asp1_r  <= in_data.aspect_ratio;
      prod_r  <= prod_nxt;
      asp2_r  <= asp1_r;
      depth_r <= depth_nxt;
      magr_r  <= magr_nxt;
      magu_r  <= magu_nxt;
      asp3_r  <= asp2_r;
      num_r   <= num_nxt;
      den_r   <= den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) side_r[i] <= '0;
    end else if (en) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < 4; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign side_o = side_r[3];
  assign num_o  = num_r;
  assign den_o  = den_r;

endmodule

// ===== src/pff_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow cap.
module pff_div #(
  parameter int NUM_W = pff_pkg::num_w(pff_pkg::COORD_BITS_DEF, pff_pkg::DIR_BITS_DEF),
  parameter int DEN_W = pff_pkg::den_w(pff_pkg::COORD_BITS_DEF, pff_pkg::DIR_BITS_DEF)
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [DEN_W-1:0]          den_i,
  output logic [pff_pkg::TAN_W-1:0] quo_o,
  output logic                      cap_o
);
  import pff_pkg::*;

  localparam int CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  logic [NUM_W-1:0] rem_r [TAN_W-1];
  logic [DEN_W-1:0] den_r [TAN_W-1];
  logic [TAN_W-1:0] quo_r [TAN_W];
  logic             cap_r [TAN_W];

  for (genvar s = 0; s < TAN_W; s++) begin : g_stage
    localparam int I = TAN_W - 1 - s;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [TAN_W-1:0] quo_in;
    logic             cap_in;
    logic [CW-1:0]    hi;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign cap_in = CW'(num_i >> TAN_W) >= CW'(den_i);
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign cap_in = cap_r[s-1];
    end

    assign hi   = CW'(rem_in >> I);
    assign take = hi >= CW'(den_in);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= quo_in | (TAN_W'(take) << I);
        cap_r[s] <= cap_in;
      end
    end

    if (s < TAN_W - 1) begin : g_keep
      logic [CW-1:0]    diff;
      logic [NUM_W-1:0] rem_nxt;
      assign diff    = hi - CW'(den_in);
      assign rem_nxt = take ? ((rem_in & ~({NUM_W{1'b1}} << I)) | (NUM_W'(diff) << I))
                            : rem_in;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign cap_o = cap_r[TAN_W-1];
  assign quo_o = cap_r[TAN_W-1] ? '1 : quo_r[TAN_W-1];

endmodule

// ===== src/pff_tanmax.sv =====
// Eight tangent dividers in parallel and a registered maximum tree.
module pff_tanmax #(
  parameter int NUM_W = pff_pkg::num_w(pff_pkg::COORD_BITS_DEF, pff_pkg::DIR_BITS_DEF),
  parameter int DEN_W = pff_pkg::den_w(pff_pkg::COORD_BITS_DEF, pff_pkg::DIR_BITS_DEF)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  pff_pkg::pff_side_t        side_i,
  input  logic [NUM_W-1:0]          num_i [pff_pkg::N_TAN],
  input  logic [DEN_W-1:0]          den_i [pff_pkg::N_TAN],
  output pff_pkg::pff_side_t        side_o,
  output logic [pff_pkg::TAN_W-1:0] tan_o
);
  import pff_pkg::*;

  logic [TAN_W-1:0] quo [N_TAN];
  logic [N_TAN-1:0] cap;
  pff_side_t        side_div_r [TAN_W];
  pff_side_t        side_a_nxt, side_a_r, side_b_r;
  logic [TAN_W-1:0] max4_nxt [4];
  logic [TAN_W-1:0] max4_r   [4];
  logic [TAN_W-1:0] max_nxt, max_r;

  for (genvar j = 0; j < N_TAN; j++) begin : g_div
    pff_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num_i[j]),
      .den_i (den_i[j]),
      .quo_o (quo[j]),
      .cap_o (cap[j])
    );
  end

  always_comb begin
    logic [TAN_W-1:0] m0, m1;
    for (int p = 0; p < 4; p++) begin
      max4_nxt[p] = (quo[2*p] > quo[2*p+1]) ? quo[2*p] : quo[2*p+1];
    end
    side_a_nxt     = side_div_r[TAN_W-1];
    side_a_nxt.sat = side_div_r[TAN_W-1].sat | (|cap);
    m0      = (max4_r[0] > max4_r[1]) ? max4_r[0] : max4_r[1];
    m1      = (max4_r[2] > max4_r[3]) ? max4_r[2] : max4_r[3];
    max_nxt = (m0 > m1) ? m0 : m1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      max4_r <= max4_nxt;
      max_r  <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAN_W; i++) side_div_r[i] <= '0;
      side_a_r <= '0;
      side_b_r <= '0;
    end else if (en) begin
      side_div_r[0] <= side_i;
      for (int i = 1; i < TAN_W; i++) side_div_r[i] <= side_div_r[i-1];
      side_a_r <= side_a_nxt;
      side_b_r <= side_a_r;
    end
  end

  assign side_o = side_b_r;
  assign tan_o  = max_r;

endmodule

// ===== src/pff_cordic.sv =====
// Margin scaling and pipelined vectoring arctangent, one step per stage.
module pff_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  pff_pkg::pff_side_t             side_i,
  input  logic [pff_pkg::TAN_W-1:0]      tan_i,
  input  logic [pff_pkg::MARGIN_W-1:0]   margin,
  output pff_pkg::pff_side_t             side_o,
  output logic [pff_pkg::ANG_FULL_W-1:0] ang_o
);
  import pff_pkg::*;

  localparam int PW = TAN_W + MARGIN_W + 1;

  logic [PW-1:0]          prod;
  logic [SCALED_W-1:0]    scaled_r;
  logic signed [XY_W-1:0] x_r [CORDIC_STEPS-1];
  logic signed [XY_W-1:0] y_r [CORDIC_STEPS-1];
  logic signed [Z_W-1:0]  z_r [CORDIC_STEPS];
  pff_side_t              side_r [CORDIC_STEPS+1];
  logic [Z_W-1:0]         zc;
  logic [Z_W-1:0]         zsum;

  assign prod = PW'(tan_i) * PW'(margin) + PW'(1 << (MARGIN_FRAC - 1));

  always_ff @(posedge clk) begin
    if (en) scaled_r <= prod[PW-1:MARGIN_FRAC];
  end

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
    logic signed [XY_W-1:0] x_in, y_in, y_mag;
    logic signed [Z_W-1:0]  z_in;
    logic                   neg;

    if (s == 0) begin : g_first
      assign x_in = XY_W'(1) <<< CORDIC_X0_SH;
      assign y_in = XY_W'(scaled_r) <<< CORDIC_PRE;
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_r[s-1];
      assign y_in = y_r[s-1];
      assign z_in = z_r[s-1];
    end

    assign neg   = y_in[XY_W-1];
    assign y_mag = neg ? -y_in : y_in;

    always_ff @(posedge clk) begin
      if (en) z_r[s] <= neg ? z_in - atan_q24(s) : z_in + atan_q24(s);
    end

    if (s < CORDIC_STEPS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[s] <= x_in + (y_mag >>> s);
          y_r[s] <= neg ? y_in + (x_in >>> s) : y_in - (x_in >>> s);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) side_r[i] <= '0;
    end else if (en) begin
      side_r[0] <= side_i;
      for (int i = 1; i <= CORDIC_STEPS; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign zc     = z_r[CORDIC_STEPS-1][Z_W-1] ? '0 : z_r[CORDIC_STEPS-1];
  assign zsum   = zc + Z_W'(ANG_ROUND);
  assign ang_o  = ANG_FULL_W'(zsum >> ANG_SHIFT);
  assign side_o = side_r[CORDIC_STEPS];

endmodule

// ===== src/pane_frustum_fov_fit.sv =====
// Top level of the pane frustum field-of-view fit pipeline.
// Throughput: one word per cycle; all stages advance while the output word is absent or taken.
// Stages: 4 geometry, 32 divider, 2 max tree, 25 scaling and arctangent, 1 clamp and output.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the configuration registers.
module pane_frustum_fov_fit #(
  parameter int COORD_BITS = pff_pkg::COORD_BITS_DEF,
  parameter int DIR_BITS   = pff_pkg::DIR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pff_pkg::pff_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pff_pkg::pff_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pff_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pff_pkg::*;

  localparam int NUM_W = num_w(COORD_BITS, DIR_BITS);
  localparam int DEN_W = den_w(COORD_BITS, DIR_BITS);

  logic                  en;
  logic [ANG_W-1:0]      fov_min_r, fov_max_r;
  logic [MARGIN_W-1:0]   margin_r;
  logic [FLOOR_W-1:0]    floor_r;
  pff_side_t             side_g, side_t, side_c;
  logic [NUM_W-1:0]      div_num [N_TAN];
  logic [DEN_W-1:0]      div_den [N_TAN];
  logic [TAN_W-1:0]      tan_max;
  logic [ANG_FULL_W-1:0] ang;
  pff_out_t              out_nxt, out_r;
  logic                  out_vld_r;

  assign en        = !out_vld_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fov_min_r <= FOV_MIN_RST;
      fov_max_r <= FOV_MAX_RST;
      margin_r  <= FIT_MARGIN_RST;
      floor_r   <= DEPTH_FLR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOV_MIN:    fov_min_r <= cfg_data[ANG_W-1:0];
        REG_FOV_MAX:    fov_max_r <= cfg_data[ANG_W-1:0];
        REG_FIT_MARGIN: margin_r  <= cfg_data[MARGIN_W-1:0];
        REG_DEPTH_FLR:  floor_r   <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  pff_geom #(
    .COORD_BITS (COORD_BITS),
    .DIR_BITS   (DIR_BITS)
  ) u_geom (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (in_valid),
    .in_data     (in_data),
    .depth_floor (floor_r),
    .side_o      (side_g),
    .num_o       (div_num),
    .den_o       (div_den)
  );

  pff_tanmax #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_tanmax (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (side_g),
    .num_i  (div_num),
    .den_i  (div_den),
    .side_o (side_t),
    .tan_o  (tan_max)
  );

  pff_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (side_t),
    .tan_i  (tan_max),
    .margin (margin_r),
    .side_o (side_c),
    .ang_o  (ang)
  );

  always_comb begin
    logic [ANG_FULL_W-1:0] fov;
    logic                  sat;
    fov = ang;
    sat = side_c.sat;
    if (fov < ANG_FULL_W'(fov_min_r)) begin
      fov = ANG_FULL_W'(fov_min_r);
      sat = 1'b1;
    end
    if (fov > ANG_FULL_W'(fov_max_r)) begin
      fov = ANG_FULL_W'(fov_max_r);
      sat = 1'b1;
    end
    if (side_c.zero) begin
      fov = ANG_FULL_W'(fov_max_r);
      sat = 1'b1;
    end
    out_nxt.field_of_view = fov[ANG_W-1:0];
    out_nxt.saturated     = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= side_c.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_unsat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.saturated |->
      out_r.field_of_view >= fov_min_r && out_r.field_of_view <= fov_max_r)
    else $error("unsaturated result outside the configured limits");

  a_stall_holds_tan: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(side_t.vld) && $stable(tan_max))
    else $error("tangent stage moved during a stall");

  a_cap_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    side_t.vld && side_t.sat |-> &tan_max)
    else $error("capped tangent is not all ones");
`endif

endmodule
